// File: design/tsg_pkg.sv
// Package for the three-axis step generator: sequencer states, operation
// and block-kind codes, field widths and arithmetic constants.
// No dependencies.
`default_nettype none
package tsg_pkg;

  localparam int AXES_DEF   = 3;
  localparam int TGT_W      = 16;
  localparam int POS_W      = 32;
  localparam int TPM_W      = 8;
  localparam int MS_W       = 16;
  localparam int MS_PER_S   = 1000;
  localparam int MS_PER_S_W = 10;
  localparam int DIV_W      = POS_W + MS_PER_S_W;
  localparam int DVS_W      = TGT_W - 1;

  localparam logic [TPM_W-1:0] TPM_RESET = 8'd25;
  localparam logic [MS_W-1:0]  DUR_MAX   = 16'd32767;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ABORT = 2'd1,
    OP_ZERO  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_REL  = 2'd0,
    KIND_ABS  = 2'd1,
    KIND_AT   = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_PER,
    S_ERR,
    S_TICK,
    S_STEP,
    S_END,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// File: design/tsg_if.sv
// Valid/ready channel interfaces for tick items and step results.
// Depends on nothing but the field widths written out below.
`default_nettype none
interface tsg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               block_offered;
  logic [1:0]         block_kind;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_z;
  logic signed [15:0] time_or_speed;
  logic               more_pending;

  modport source (output valid, opcode, block_offered, block_kind, target_x, target_y,
                  target_z, time_or_speed, more_pending, input ready);
  modport sink   (input valid, opcode, block_offered, block_kind, target_x, target_y,
                  target_z, time_or_speed, more_pending, output ready);
endinterface

interface tsg_out_if;
  logic               valid;
  logic               ready;
  logic               block_taken;
  logic               step_x;
  logic               step_y;
  logic               step_z;
  logic               dir_x;
  logic               dir_y;
  logic               dir_z;
  logic               busy_res;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, block_taken, step_x, step_y, step_z, dir_x, dir_y, dir_z,
                  busy_res, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, block_taken, step_x, step_y, step_z, dir_x, dir_y, dir_z,
                  busy_res, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

// File: design/tsg_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; widths come from its parameters.
`default_nettype none
module tsg_div #(
  parameter int DW = 42,
  parameter int VW = 15
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  always_comb begin
    trial    = {rem_r, q_r[DW-1]};
    diff     = trial - {1'b0, divisor};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      q_nxt   = dividend;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[VW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// File: design/three_axis_step_generator_top.sv
// Three-axis Bresenham step generator, built around a small sequencer.
// A running tick passes S_TICK, S_STEP for each axis, S_END and S_OUT; idle or control items
// go straight to S_OUT. Starting a block adds S_DELTA per axis, S_PER and S_ERR per axis, and
// an absolute move also S_MUL, S_DSTART and the S_DIV wait for the divider (42 quotient bits).
// One item at a time. Reset (rst_n, synchronous, active low) clears positions, errors, deltas,
// the period, counters and active flag, and sets ticks_per_ms to 25.
`default_nettype none
module three_axis_step_generator_top #(
  parameter int AXES = tsg_pkg::AXES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  tsg_in_if.sink          in_ch,
  tsg_out_if.source       out_ch
);
  import tsg_pkg::*;

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [AW-1:0] LAST_AXIS = AW'(AXES - 1);

  // Sequencer and latched item.
  state_t               state_r, state_nxt;
  logic [AW-1:0]        axis_r, axis_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [TGT_W-1:0]     tgt_r [3];
  logic [TGT_W-1:0]     tgt_nxt [3];
  logic [TGT_W-1:0]     ts_r, ts_nxt;
  logic                 more_r, more_nxt;
  logic [TPM_W-1:0]     tpm_r;

  // Motion state.
  logic [POS_W-1:0]     pos_r [AXES];
  logic [POS_W-1:0]     pos_nxt [AXES];
  logic [POS_W-1:0]     err_r [AXES];
  logic [POS_W-1:0]     err_nxt [AXES];
  logic [POS_W-1:0]     dlt_r [AXES];
  logic [POS_W-1:0]     dlt_nxt [AXES];
  logic [AXES-1:0]      neg_r, neg_nxt;
  logic [AXES-1:0]      step_r, step_nxt;
  logic [POS_W-1:0]     period_r, period_nxt;
  logic [POS_W-1:0]     half_r, half_nxt;
  logic [POS_W-1:0]     nmax_r, nmax_nxt;
  logic [DIV_W-1:0]     prod_r, prod_nxt;
  logic [TPM_W-1:0]     tick_r, tick_nxt;
  logic [MS_W-1:0]      ms_r, ms_nxt;
  logic [MS_W-1:0]      dur_r, dur_nxt;
  logic                 active_r, active_nxt;
  logic [1:0]           akind_r, akind_nxt;
  logic                 taken_r, taken_nxt;

  // Shared datapath terms.
  logic [TGT_W-1:0]     tgt_sel;
  logic [POS_W-1:0]     dsub;
  logic [POS_W-1:0]     dmag;
  logic [POS_W-1:0]     per;
  logic                 err_pos;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_W-1:0]     div_q;
  logic                 ts_pos;
  logic [TPM_W-1:0]     tick_inc;

  tsg_div #(.DW(DIV_W), .VW(DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (ts_r[DVS_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign ts_pos = !in_ch.time_or_speed[TGT_W-1] && (in_ch.time_or_speed != '0);

  always_comb begin
    tgt_sel = '0;
    if (axis_r == AW'(0))      tgt_sel = tgt_r[0];
    else if (axis_r == AW'(1)) tgt_sel = tgt_r[1];
    else if (axis_r == AW'(2)) tgt_sel = tgt_r[2];
  end

  // One axis per cycle goes through the shared subtract/negate and the step adder.
  assign dsub = {{(POS_W-TGT_W){tgt_sel[TGT_W-1]}}, tgt_sel}
              - ((kind_r == KIND_ABS) ? pos_r[axis_r] : '0);
  assign dmag = dsub[POS_W-1] ? (~dsub + 1'b1) : dsub;
  assign per  = POS_W'($signed({{(POS_W-TPM_W){1'b0}}, tpm_r})
                     * $signed({{(POS_W-MS_W){dur_r[MS_W-1]}}, dur_r}));
  assign err_pos = (err_r[axis_r] != '0) && !err_r[axis_r][POS_W-1];
  assign tick_inc = tick_r + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    kind_nxt   = kind_r;
    tgt_nxt    = tgt_r;
    ts_nxt     = ts_r;
    more_nxt   = more_r;
    pos_nxt    = pos_r;
    err_nxt    = err_r;
    dlt_nxt    = dlt_r;
    neg_nxt    = neg_r;
    step_nxt   = step_r;
    period_nxt = period_r;
    half_nxt   = half_r;
    nmax_nxt   = nmax_r;
    prod_nxt   = prod_r;
    tick_nxt   = tick_r;
    ms_nxt     = ms_r;
    dur_nxt    = dur_r;
    active_nxt = active_r;
    akind_nxt  = akind_r;
    taken_nxt  = taken_r;
    div_start  = 1'b0;
    in_ch.ready = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt   = in_ch.block_kind;
          tgt_nxt[0] = in_ch.target_x;
          tgt_nxt[1] = in_ch.target_y;
          tgt_nxt[2] = in_ch.target_z;
          ts_nxt     = in_ch.time_or_speed;
          more_nxt   = in_ch.more_pending;
          taken_nxt  = 1'b0;
          step_nxt   = '0;
          axis_nxt   = '0;
          state_nxt  = S_OUT;
          case (in_ch.opcode)
            OP_ABORT: begin
              active_nxt = 1'b0;
              tick_nxt   = '0;
              ms_nxt     = '0;
            end
            OP_ZERO: begin
              for (int i = 0; i < AXES; i++) begin
                pos_nxt[i] = '0;
                err_nxt[i] = '0;
              end
            end
            OP_TICK: begin
              if (active_r) begin
                state_nxt = S_TICK;
              end else if (in_ch.block_offered) begin
                taken_nxt = 1'b1;
                // Kind three, and relative or absolute moves without a positive
                // time or speed, are consumed but never started.
                if (!(in_ch.block_kind == KIND_NONE ||
                      ((in_ch.block_kind == KIND_REL || in_ch.block_kind == KIND_ABS)
                       && !ts_pos))) begin
                  nmax_nxt  = '0;
                  tick_nxt  = '0;
                  ms_nxt    = '0;
                  state_nxt = S_DELTA;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_DELTA: begin
        dlt_nxt[axis_r] = dmag;
        neg_nxt[axis_r] = dsub[POS_W-1];
        if (dmag > nmax_r) nmax_nxt = dmag;
        axis_nxt = axis_r + 1'b1;
        if (axis_r == LAST_AXIS) begin
          axis_nxt = '0;
          if (kind_r == KIND_ABS) begin
            state_nxt = S_MUL;
          end else begin
            dur_nxt   = ts_r;
            state_nxt = S_PER;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = DIV_W'(nmax_r) * DIV_W'(MS_PER_S);
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          dur_nxt   = (div_q > DIV_W'(DUR_MAX)) ? DUR_MAX : div_q[MS_W-1:0];
          state_nxt = S_PER;
        end
      end
      S_PER: begin
        period_nxt = per;
        half_nxt   = POS_W'($signed(per + POS_W'(per[POS_W-1])) >>> 1);
        state_nxt  = S_ERR;
      end
      S_ERR: begin
        err_nxt[axis_r] = dlt_r[axis_r] - half_r;
        axis_nxt = axis_r + 1'b1;
        if (axis_r == LAST_AXIS) begin
          axis_nxt   = '0;
          akind_nxt  = kind_r;
          active_nxt = 1'b1;
          state_nxt  = S_TICK;
        end
      end
      S_TICK: begin
        if (tick_inc == tpm_r) begin
          tick_nxt = '0;
          ms_nxt   = ms_r + 1'b1;
        end else begin
          tick_nxt = tick_inc;
        end
        axis_nxt  = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        step_nxt[axis_r] = err_pos;
        if (err_pos) begin
          pos_nxt[axis_r] = neg_r[axis_r] ? pos_r[axis_r] - 1'b1 : pos_r[axis_r] + 1'b1;
          err_nxt[axis_r] = err_r[axis_r] - period_r + dlt_r[axis_r];
        end else begin
          err_nxt[axis_r] = err_r[axis_r] + dlt_r[axis_r];
        end
        axis_nxt = axis_r + 1'b1;
        if (axis_r == LAST_AXIS) begin
          axis_nxt  = '0;
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (akind_r == KIND_AT) begin
          if (more_r) active_nxt = 1'b0;
        end else if (ms_r >= dur_r) begin
          active_nxt = 1'b0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      axis_r   <= '0;
      tpm_r    <= TPM_RESET;
      for (int i = 0; i < AXES; i++) begin
        pos_r[i] <= '0;
        err_r[i] <= '0;
        dlt_r[i] <= '0;
      end
      neg_r    <= '0;
      step_r   <= '0;
      period_r <= '0;
      tick_r   <= '0;
      ms_r     <= '0;
      dur_r    <= '0;
      active_r <= 1'b0;
      akind_r  <= '0;
      taken_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      axis_r   <= axis_nxt;
      if (cfg_we) tpm_r <= cfg_wdata;
      pos_r    <= pos_nxt;
      err_r    <= err_nxt;
      dlt_r    <= dlt_nxt;
      neg_r    <= neg_nxt;
      step_r   <= step_nxt;
      period_r <= period_nxt;
      tick_r   <= tick_nxt;
      ms_r     <= ms_nxt;
      dur_r    <= dur_nxt;
      active_r <= active_nxt;
      akind_r  <= akind_nxt;
      taken_r  <= taken_nxt;
    end
    kind_r <= kind_nxt;
    tgt_r  <= tgt_nxt;
    ts_r   <= ts_nxt;
    more_r <= more_nxt;
    half_r <= half_nxt;
    nmax_r <= nmax_nxt;
    prod_r <= prod_nxt;
  end

  // Only the first three axes have result fields; missing ones read as zero.
  logic [2:0]       step3;
  logic [2:0]       dir3;
  logic [POS_W-1:0] pos3 [3];

  for (genvar k = 0; k < 3; k++) begin : g_out
    if (k < AXES) begin : g_have
      assign step3[k] = step_r[k];
      assign dir3[k]  = neg_r[k];
      assign pos3[k]  = pos_r[k];
    end else begin : g_none
      assign step3[k] = 1'b0;
      assign dir3[k]  = 1'b0;
      assign pos3[k]  = '0;
    end
  end

  // The result is held in registers while the sequencer waits for the transfer.
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.block_taken = taken_r;
  assign out_ch.step_x      = step3[0];
  assign out_ch.step_y      = step3[1];
  assign out_ch.step_z      = step3[2];
  assign out_ch.dir_x       = dir3[0];
  assign out_ch.dir_y       = dir3[1];
  assign out_ch.dir_z       = dir3[2];
  assign out_ch.busy_res    = active_r;
  assign out_ch.pos_x       = pos3[0];
  assign out_ch.pos_y       = pos3[1];
  assign out_ch.pos_z       = pos3[2];

  // A new item is never taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while a result is pending");

  // A stalled result keeps the sequencer parked and pos_x unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.pos_x)))
    else $error("result changed under stall");

  // The divider only finishes while the sequencer waits for it.
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  // A block that was dropped gives no step pulses.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.block_taken && !out_ch.busy_res && $past(state_r) == S_IDLE)
    |-> (step_r == '0))
    else $error("step pulse on a dropped block");

endmodule
`default_nettype wire

// File: test/tsg_checker.sv
// Checker for the three-axis step generator: watches the tick and result channels
// and the ticks_per_ms write port, predicts every result and compares it.
// Depends on tsg_pkg and the channel interfaces in tsg_if.sv.
`default_nettype none
module tsg_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  tsg_in_if               in_ch,
  tsg_out_if              out_ch,
  output int              n_fail,
  output int              n_waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsg_pkg::*;

  typedef struct packed {
    logic        taken;
    logic [2:0]  stp;
    logic [2:0]  dir;
    logic        busy;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } step_result_t;

  step_result_t pending_results[$];

  logic [31:0] pos [3];
  logic [31:0] err [3];
  logic [31:0] dlt [3];
  logic [2:0]  neg;
  logic [31:0] period;
  logic [7:0]  tick_cnt;
  logic [15:0] ms_cnt;
  logic        active;
  kind_t       act_kind;
  logic [15:0] dur;
  logic [7:0]  tpm;

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Loads a new block; returns 0 when the block is dropped.
  function automatic logic load_block(kind_t kind, logic [15:0] tx, logic [15:0] ty,
                                      logic [15:0] tz, logic [15:0] ts);
    logic [31:0] tsv;
    logic [31:0] d;
    logic [31:0] nmax;
    logic [15:0] tg [3];
    longint unsigned q;
    longint dsx;
    longint per;
    longint per_half;
    tsv = sext16(ts);
    if (kind == KIND_NONE || (kind != KIND_AT && $signed(tsv) <= 0)) return 1'b0;
    tg[0] = tx; tg[1] = ty; tg[2] = tz;
    tick_cnt = '0;
    ms_cnt = '0;
    nmax = '0;
    for (int i = 0; i < 3; i++) begin
      d = sext16(tg[i]);
      if (kind == KIND_ABS) d = d - pos[i];
      neg[i] = d[31];
      if (d[31]) d = -d;
      dlt[i] = d;
      if (d > nmax) nmax = d;
    end
    if (kind == KIND_ABS) begin
      q = (64'd1000 * nmax) / {32'd0, tsv};
      dur = (q > 64'd32767) ? 16'd32767 : q[15:0];
    end else begin
      dur = ts;
    end
    dsx = $signed(dur);
    per = longint'({56'd0, tpm}) * dsx;
    period = per[31:0];
    per_half = per / 2;
    for (int i = 0; i < 3; i++) err[i] = dlt[i] - per_half[31:0];
    act_kind = kind;
    active = 1'b1;
    return 1'b1;
  endfunction

  function automatic step_result_t predict_step();
    step_result_t r;
    logic run;
    r = '0;
    case (opcode_t'(in_ch.opcode))
      OP_ABORT: begin
        active = 1'b0;
        tick_cnt = '0;
        ms_cnt = '0;
      end
      OP_ZERO: begin
        for (int i = 0; i < 3; i++) begin
          pos[i] = '0;
          err[i] = '0;
        end
      end
      OP_TICK: begin
        run = active;
        if (!active && in_ch.block_offered) begin
          r.taken = 1'b1;
          run = load_block(kind_t'(in_ch.block_kind), in_ch.target_x, in_ch.target_y,
                           in_ch.target_z, in_ch.time_or_speed);
        end
        if (run) begin
          tick_cnt = tick_cnt + 8'd1;
          if (tick_cnt == tpm) begin
            tick_cnt = '0;
            ms_cnt = ms_cnt + 16'd1;
          end
          for (int i = 0; i < 3; i++) begin
            if (err[i] != 0 && !err[i][31]) begin
              r.stp[i] = 1'b1;
              pos[i] = neg[i] ? pos[i] - 32'd1 : pos[i] + 32'd1;
              err[i] = err[i] - period;
            end
            err[i] = err[i] + dlt[i];
          end
          if (act_kind == KIND_AT) begin
            if (in_ch.more_pending) active = 1'b0;
          end else if (ms_cnt >= dur) begin
            active = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.dir = neg;
    r.busy = active;
    r.px = pos[0];
    r.py = pos[1];
    r.pz = pos[2];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  initial begin
    n_fail = 0;
    n_waiting = 0;
  end

  always @(posedge clk) begin
    step_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] = '0; err[i] = '0; dlt[i] = '0;
      end
      neg = '0; period = '0; tick_cnt = '0; ms_cnt = '0;
      active = 1'b0; act_kind = KIND_REL; dur = '0; tpm = TPM_RESET;
      pending_results.delete();
    end else begin
      // Retire the older expectation before adding the one from this edge.
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no expected result waiting");
          n_fail++;
        end else begin
          e = pending_results.pop_front();
          check_field("block_taken", e.taken, out_ch.block_taken);
          check_field("step_x", e.stp[0], out_ch.step_x);
          check_field("step_y", e.stp[1], out_ch.step_y);
          check_field("step_z", e.stp[2], out_ch.step_z);
          check_field("dir_x", e.dir[0], out_ch.dir_x);
          check_field("dir_y", e.dir[1], out_ch.dir_y);
          check_field("dir_z", e.dir[2], out_ch.dir_z);
          check_field("busy_res", e.busy, out_ch.busy_res);
          check_field("pos_x", e.px, out_ch.pos_x);
          check_field("pos_y", e.py, out_ch.pos_y);
          check_field("pos_z", e.pz, out_ch.pos_z);
        end
      end
      if (in_ch.valid && in_ch.ready) pending_results.push_back(predict_step());
      if (cfg_we) tpm = cfg_wdata;
    end
    n_waiting = pending_results.size();
  end
endmodule
`default_nettype wire

// File: test/tb_three_axis_step_generator_top.sv
// Top of the step generator testbench: clock, reset, tick stimulus, result
// back-pressure, ticks_per_ms phases and the verdict.
// Depends on tsg_pkg, tsg_if.sv, tsg_checker and the block itself.
`default_nettype none
module tb_three_axis_step_generator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tsg_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         n_fail;
  int         n_waiting;
  int         cycles;

  tsg_in_if  in_ch ();
  tsg_out_if out_ch ();

  three_axis_step_generator_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  tsg_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .n_fail   (n_fail),
    .n_waiting(n_waiting)
  );

  // One tick-channel item, kept in the field widths of the interface.
  typedef struct packed {
    opcode_t     op;
    logic        offered;
    kind_t       kind;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic [15:0] ts;
    logic        more;
  } tick_item_t;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The cycle counter is the only timeout; it fires far above the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL three_axis_step_generator_top");
      $finish;
    end
  end

  // Result side: ready is dropped for a random stall, possibly none, before each transfer,
  // except during runs where the receiver keeps ready high throughout.
  initial begin
    int stall;
    bit eager;
    out_ch.ready = 1'b0;
    eager = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 19) == 0) eager = !eager;
      stall = eager ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Sends one item after a random gap; returns at the falling edge after its transfer.
  task automatic send_item(tick_item_t it, bit eager);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.opcode        <= it.op;
    in_ch.block_offered <= it.offered;
    in_ch.block_kind    <= it.kind;
    in_ch.target_x      <= it.tx;
    in_ch.target_y      <= it.ty;
    in_ch.target_z      <= it.tz;
    in_ch.time_or_speed <= it.ts;
    in_ch.more_pending  <= it.more;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic directed(opcode_t op, logic offered, kind_t kind, int tx, int ty, int tz,
                          int ts, logic more);
    tick_item_t it;
    it = '{op, offered, kind, tx[15:0], ty[15:0], tz[15:0], ts[15:0], more};
    send_item(it, 1'b0);
  endtask

  // Waits with the sender quiet until every expected result has been transferred.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (n_waiting != 0) @(negedge clk);
  endtask

  task automatic write_tpm(logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly ticks with small moves so blocks finish or get aborted quickly; now and
  // then every field takes a fully random value so that all bits toggle.
  function automatic tick_item_t random_item();
    tick_item_t it;
    int pick;
    it = '0;
    pick = $urandom_range(0, 99);
    if (pick < 84) it.op = OP_TICK;
    else if (pick < 90) it.op = OP_ABORT;
    else if (pick < 95) it.op = OP_ZERO;
    else it.op = OP_NOP;
    it.offered = ($urandom_range(0, 2) != 0);
    it.kind = kind_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) begin
      it.tx = 16'($urandom());
      it.ty = 16'($urandom());
      it.tz = 16'($urandom());
    end else begin
      it.tx = 16'($signed($urandom_range(0, 40)) - 20);
      it.ty = 16'($signed($urandom_range(0, 40)) - 20);
      it.tz = 16'($signed($urandom_range(0, 40)) - 20);
    end
    if ($urandom_range(0, 11) == 0) it.ts = 16'($urandom());
    else if (it.kind == KIND_ABS) it.ts = 16'($urandom_range(1000, 32767));
    else it.ts = 16'($signed($urandom_range(0, 8)) - 1);
    it.more = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  initial begin
    logic [7:0] tpm_phases [5];
    int per_phase;
    bit eager;
    tpm_phases = '{8'd25, 8'd255, 8'd2, 8'd0, 8'd3};
    cycles        = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = OP_TICK;
    in_ch.block_offered = 1'b0;
    in_ch.block_kind    = KIND_REL;
    in_ch.target_x      = '0;
    in_ch.target_y      = '0;
    in_ch.target_z      = '0;
    in_ch.time_or_speed = '0;
    in_ch.more_pending  = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, one tick per millisecond so moves stay short.
    write_tpm(8'd1);
    directed(OP_TICK, 1, KIND_REL, 32767, -32768, 5, 2, 0);
    directed(OP_TICK, 0, KIND_REL, 0, 0, 0, 0, 0);
    // Invalid blocks are consumed without starting.
    directed(OP_TICK, 1, KIND_REL, 3, 3, 3, 0, 0);
    directed(OP_TICK, 1, KIND_REL, 3, 3, 3, -32768, 0);
    directed(OP_TICK, 1, KIND_ABS, 3, 3, 3, 0, 0);
    directed(OP_TICK, 1, KIND_ABS, 3, 3, 3, -5, 0);
    directed(OP_TICK, 1, KIND_NONE, 3, 3, 3, 4, 0);
    // Absolute moves whose duration rounds to zero end after their first tick.
    directed(OP_ZERO, 0, KIND_REL, 0, 0, 0, 0, 0);
    directed(OP_TICK, 1, KIND_ABS, 0, 0, 0, 100, 0);
    directed(OP_TICK, 1, KIND_ABS, 3, -2, 1, 32767, 0);
    // Move-at with a negative duration, zeroed mid-block, ended by a waiting block.
    directed(OP_TICK, 1, KIND_AT, -7, 9, 1, -3, 0);
    directed(OP_TICK, 1, KIND_REL, 1, 1, 1, 1, 0);
    directed(OP_ZERO, 0, KIND_REL, 0, 0, 0, 0, 0);
    directed(OP_TICK, 0, KIND_REL, 0, 0, 0, 0, 1);
    directed(OP_TICK, 1, KIND_AT, 2, 2, 2, 5, 0);
    directed(OP_ABORT, 1, KIND_REL, 0, 0, 0, 0, 0);
    directed(OP_NOP, 1, KIND_REL, 4, 4, 4, 4, 0);
    directed(OP_TICK, 1, KIND_REL, -1, 0, 7, 1, 1);
    directed(OP_TICK, 0, KIND_REL, 0, 0, 0, 0, 0);

    // Random phases; each ticks_per_ms write happens with the block drained,
    // which also makes the sender wait for every outstanding result.
    per_phase = 130;
    eager = 1'b0;
    foreach (tpm_phases[p]) begin
      drain();
      write_tpm(tpm_phases[p]);
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 24) == 0) eager = !eager;
        send_item(random_item(), eager);
      end
    end
    drain();
    repeat (100) @(negedge clk);
    if (n_fail == 0 && n_waiting == 0) begin
      $display("PASS three_axis_step_generator_top");
    end else begin
      $display("FAIL three_axis_step_generator_top");
    end
    $finish;
  end
endmodule
`default_nettype wire
